// ===== rtl/ssa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssa_pkg;

   // Field and state widths
   localparam int SAMPLE_W   = 24;
   localparam int SUM_W      = 32;
   localparam int CNT_W      = 7;
   localparam int ELAPSED_W  = 16;
   localparam int TIMEOUT_W  = 16;
   localparam int KIND_W     = 3;
   localparam int QTY_W      = 2;
   localparam int NUM_QTY    = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_SAMPLE           = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ_PRESSURE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ_TEMPERATURE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ_AIRSPEED    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TICK             = 3'd4;

   // Quantity codes on the response
   localparam logic [QTY_W-1:0] QTY_PRESSURE    = 2'd0;
   localparam logic [QTY_W-1:0] QTY_TEMPERATURE = 2'd1;
   localparam logic [QTY_W-1:0] QTY_AIRSPEED    = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_ENABLED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 1'b1;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 16'hFFFF;

   // Saturation limits of the average
   localparam logic [SAMPLE_W-1:0] AVG_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] AVG_MIN = 24'h800000;

   // Controller to datapath commands
   typedef struct packed {
      logic sample_en;
      logic tick_en;
      logic read_start;
      logic load_rsp;
   } ssa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sel_empty;
      logic div_done;
   } ssa_sts_type;

endpackage

`default_nettype wire

// ===== rtl/ssa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssa_div import ssa_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic [SUM_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [SUM_W-1:0]  quo_in;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  rem_in;
   logic [CNT_W-1:0]  divisor_ff;
   logic [CNT_W:0]    rem_shift;
   logic [CNT_W:0]    rem_sub;
   logic              fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      rem_sub   = rem_shift - {1'b0, divisor_ff};
      fits      = (rem_shift >= {1'b0, divisor_ff});
      rem_in    = fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      quo_in    = {quo_ff[SUM_W-2:0], fits};
   end

   // Step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == LAST_STEP);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Remainder and quotient shift register
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/ssa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssa_dp import ssa_pkg::*; #(
   parameter int MAX_COUNT = 100
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ssa_cmd_type           cmd,
   output ssa_sts_type                sts,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [SAMPLE_W-1:0]   req_pressure_sample,
   input  wire logic [SAMPLE_W-1:0]   req_temperature_sample,
   input  wire logic [SAMPLE_W-1:0]   req_airspeed_sample,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [QTY_W-1:0]           rsp_quantity,
   output logic                       rsp_has_data,
   output logic [SAMPLE_W-1:0]        rsp_average,
   output logic                       rsp_fresh,
   output logic                       rsp_source_present
);

   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_COUNT);

   logic [SAMPLE_W-1:0]  samp [NUM_QTY];
   logic [SUM_W-1:0]     sum_ff [NUM_QTY];
   logic [CNT_W-1:0]     cnt_ff [NUM_QTY];
   logic [SUM_W-1:0]     sum_in [NUM_QTY];
   logic [CNT_W-1:0]     cnt_in [NUM_QTY];

   logic                 ext_enabled_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;

   logic [KIND_W-1:0]    sel_wide;
   logic [QTY_W-1:0]     sel;
   logic [SUM_W-1:0]     sel_sum;
   logic [CNT_W-1:0]     sel_cnt;
   logic [SUM_W-1:0]     sel_mag;

   logic                 div_done;
   logic [SUM_W-1:0]     quotient;

   logic [QTY_W-1:0]     qty_ff;
   logic                 has_ff;
   logic                 neg_ff;
   logic                 fresh_ff;
   logic [SAMPLE_W-1:0]  avg_in;

   logic [QTY_W-1:0]     rsp_quantity_ff;
   logic                 rsp_has_data_ff;
   logic [SAMPLE_W-1:0]  rsp_average_ff;
   logic                 rsp_fresh_ff;
   logic                 rsp_source_present_ff;

   assign samp[QTY_PRESSURE]    = req_pressure_sample;
   assign samp[QTY_TEMPERATURE] = req_temperature_sample;
   assign samp[QTY_AIRSPEED]    = req_airspeed_sample;

   // Select the quantity that a read names
   assign sel_wide = req_kind - KIND_READ_PRESSURE;
   assign sel      = sel_wide[QTY_W-1:0];

   always_comb begin
      unique case (sel)
         QTY_PRESSURE: begin
            sel_sum = sum_ff[QTY_PRESSURE];
            sel_cnt = cnt_ff[QTY_PRESSURE];
         end
         QTY_TEMPERATURE: begin
            sel_sum = sum_ff[QTY_TEMPERATURE];
            sel_cnt = cnt_ff[QTY_TEMPERATURE];
         end
         QTY_AIRSPEED: begin
            sel_sum = sum_ff[QTY_AIRSPEED];
            sel_cnt = cnt_ff[QTY_AIRSPEED];
         end
         default: begin
            sel_sum = '0;
            sel_cnt = '0;
         end
      endcase
      sel_mag = sel_sum[SUM_W-1] ? (~sel_sum + 1'b1) : sel_sum;
   end

   assign sts.sel_empty = (sel_cnt == '0);
   assign sts.div_done  = div_done;

   // Accumulator lanes: add, then halve sum and count past the limit
   for (genvar g = 0; g < NUM_QTY; g++) begin : g_lane
      logic [SUM_W-1:0] sum_add;
      logic [CNT_W-1:0] cnt_inc;

      always_comb begin
         sum_add   = sum_ff[g] + {{(SUM_W - SAMPLE_W){samp[g][SAMPLE_W-1]}}, samp[g]};
         cnt_inc   = cnt_ff[g] + 1'b1;
         sum_in[g] = sum_ff[g];
         cnt_in[g] = cnt_ff[g];
         if (cmd.sample_en) begin
            if (cnt_inc > COUNT_LIMIT) begin
               sum_in[g] = {sum_add[SUM_W-1], sum_add[SUM_W-1:1]};
               cnt_in[g] = {1'b0, cnt_inc[CNT_W-1:1]};
            end else begin
               sum_in[g] = sum_add;
               cnt_in[g] = cnt_inc;
            end
         end else if (cmd.read_start && (sel == QTY_W'(g))) begin
            sum_in[g] = '0;
            cnt_in[g] = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sum_ff[g] <= '0;
            cnt_ff[g] <= '0;
         end else begin
            sum_ff[g] <= sum_in[g];
            cnt_ff[g] <= cnt_in[g];
         end
      end
   end

   // Configuration registers and the saturating millisecond counter
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_enabled_ff <= 1'b0;
         timeout_ff     <= TIMEOUT_RESET;
         elapsed_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_EXT_ENABLED: ext_enabled_ff <= csr_wdata[0];
               CSR_TIMEOUT:     timeout_ff     <= csr_wdata[TIMEOUT_W-1:0];
               default:         ext_enabled_ff <= ext_enabled_ff;
            endcase
         end
         if (cmd.sample_en) begin
            elapsed_ff <= '0;
         end else if (cmd.tick_en && (elapsed_ff != ELAPSED_MAX)) begin
            elapsed_ff <= elapsed_ff + 1'b1;
         end
      end
   end

   // Capture the read's flags while the divide runs
   always_ff @(posedge clock) begin
      if (cmd.read_start) begin
         qty_ff   <= sel;
         has_ff   <= !sts.sel_empty;
         neg_ff   <= sel_sum[SUM_W-1];
         fresh_ff <= (sel == QTY_AIRSPEED) && !sts.sel_empty && (elapsed_ff < timeout_ff);
      end
   end

   ssa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.read_start && !sts.sel_empty),
      .dividend (sel_mag),
      .divisor  (sel_cnt),
      .done     (div_done),
      .quotient (quotient)
   );

   // Apply the sign and saturate to the average's range
   always_comb begin
      if (!has_ff) begin
         avg_in = '0;
      end else if (!neg_ff) begin
         avg_in = (quotient[SUM_W-1:SAMPLE_W-1] != '0) ? AVG_MAX : quotient[SAMPLE_W-1:0];
      end else if ((quotient[SUM_W-1:SAMPLE_W] != '0) ||
                   (quotient[SAMPLE_W-1] && (quotient[SAMPLE_W-2:0] != '0))) begin
         avg_in = AVG_MIN;
      end else begin
         avg_in = ~quotient[SAMPLE_W-1:0] + 1'b1;
      end
   end

   // Response payload register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_quantity_ff       <= qty_ff;
         rsp_has_data_ff       <= has_ff;
         rsp_average_ff        <= avg_in;
         rsp_fresh_ff          <= fresh_ff;
         rsp_source_present_ff <= ext_enabled_ff;
      end
   end

   assign rsp_quantity       = rsp_quantity_ff;
   assign rsp_has_data       = rsp_has_data_ff;
   assign rsp_average        = rsp_average_ff;
   assign rsp_fresh          = rsp_fresh_ff;
   assign rsp_source_present = rsp_source_present_ff;

endmodule

`default_nettype wire

// ===== rtl/ssa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssa_ctrl import ssa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [KIND_W-1:0] req_kind,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire ssa_sts_type       sts,
   output ssa_cmd_type            cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      is_sample;
   logic      is_tick;
   logic      is_read;

   // Decode the request kind; unused kinds are taken and dropped
   always_comb begin
      is_sample = 1'b0;
      is_tick   = 1'b0;
      is_read   = 1'b0;
      unique case (req_kind) inside
         KIND_SAMPLE: is_sample = 1'b1;
         KIND_TICK:   is_tick   = 1'b1;
         KIND_READ_PRESSURE, KIND_READ_TEMPERATURE, KIND_READ_AIRSPEED: is_read = 1'b1;
         default: is_read = 1'b0;
      endcase
   end

   assign accept         = req_valid && (state_ff == ST_IDLE);
   assign cmd.sample_en  = accept && is_sample;
   assign cmd.tick_en    = accept && is_tick;
   assign cmd.read_start = accept && is_read;
   assign cmd.load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.read_start) begin
               state_in = sts.sel_empty ? ST_DONE : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (cmd.load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/sensor_sample_averager.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Running-sum averager for pressure, temperature and airspeed samples.
// Request channel (req_*): one beat carries a kind and three signed samples
// with 8 fractional bits. A sample beat adds to all three sums and clears the
// millisecond counter; a tick beat advances that counter, saturating at its top.
// Both give no response; unused kinds are taken and dropped.
// A read beat gives one response beat (rsp_*) with the truncated average, a
// has-data flag, a freshness flag for airspeed and the source-present bit, and
// clears that quantity. The average comes from a restoring divider that makes
// one quotient bit per cycle. A non-empty read divides, then loads its response;
// an empty read skips the divide. The next request is taken in the cycle after
// the response is loaded.
// The response waits in an output register; a stalled receiver holds it, and a
// following read finishes its divide and then waits until that beat is taken.
// Configuration (csr_*) is written at any edge with csr_wr_en high.
// Synchronous reset clears the sums, counts and counter, sets the timeout to
// 2000 ms and the source-present bit to zero, and drops any pending response.
module sensor_sample_averager import ssa_pkg::*; #(
   parameter int MAX_COUNT = 100
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [SAMPLE_W-1:0]   req_pressure_sample,
   input  wire logic [SAMPLE_W-1:0]   req_temperature_sample,
   input  wire logic [SAMPLE_W-1:0]   req_airspeed_sample,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [QTY_W-1:0]           rsp_quantity,
   output logic                       rsp_has_data,
   output logic [SAMPLE_W-1:0]        rsp_average,
   output logic                       rsp_fresh,
   output logic                       rsp_source_present,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ssa_cmd_type cmd;
   ssa_sts_type sts;

   ssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ssa_dp #(
      .MAX_COUNT (MAX_COUNT)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_kind               (req_kind),
      .req_pressure_sample    (req_pressure_sample),
      .req_temperature_sample (req_temperature_sample),
      .req_airspeed_sample    (req_airspeed_sample),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .rsp_quantity           (rsp_quantity),
      .rsp_has_data           (rsp_has_data),
      .rsp_average            (rsp_average),
      .rsp_fresh              (rsp_fresh),
      .rsp_source_present     (rsp_source_present)
   );

   // No response can be raised in the cycle right after a request beat
   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response raised right after a request beat");

   // The divider only finishes while a read is in flight
   a_div_done_busy: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> !req_ready)
      else $error("divider finished while idle");

   // An empty read carries a zero average and is never fresh
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_data) |-> ((rsp_average == '0) && !rsp_fresh))
      else $error("empty read with nonzero payload");

   // Only an airspeed read can be fresh
   a_fresh_airspeed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fresh) |-> (rsp_quantity == QTY_AIRSPEED))
      else $error("fresh flag on a non-airspeed read");

endmodule

`default_nettype wire

// ===== bench/averager_checker.sv =====
`timescale 1ns / 1ps

module averager_checker import ssa_pkg::*; #(
   parameter int MAX_COUNT = 100
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [SAMPLE_W-1:0]   req_pressure_sample,
   input  wire logic [SAMPLE_W-1:0]   req_temperature_sample,
   input  wire logic [SAMPLE_W-1:0]   req_airspeed_sample,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [QTY_W-1:0]      rsp_quantity,
   input  wire logic                  rsp_has_data,
   input  wire logic [SAMPLE_W-1:0]   rsp_average,
   input  wire logic                  rsp_fresh,
   input  wire logic                  rsp_source_present,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         outstanding
);

   localparam int REPORT_LIMIT = 200;

   typedef struct packed {
      logic [QTY_W-1:0]    quantity;
      logic                has_data;
      logic [SAMPLE_W-1:0] average;
      logic                fresh;
      logic                source_present;
   } average_reading_type;

   // Shadow copy of the accumulators, the millisecond counter and the registers
   logic [SUM_W-1:0]       sums   [NUM_QTY];
   logic [CNT_W-1:0]       counts [NUM_QTY];
   logic [ELAPSED_W-1:0]   elapsed_ms;
   logic                   ext_enabled;
   logic [TIMEOUT_W-1:0]   stale_limit;
   average_reading_type    pending_readings [$];
   int                     errors = 0;

   assign mismatch_count = errors;

   // Add one sample; halve sum and count once the count passes the limit
   function automatic void add_to_sum(input logic [QTY_W-1:0] qty,
                                      input logic [SAMPLE_W-1:0] sample);
      logic [SUM_W-1:0] widened;
      widened = {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      sums[qty] = sums[qty] + widened;
      counts[qty] = counts[qty] + 1'b1;
      if (counts[qty] > MAX_COUNT) begin
         sums[qty] = $signed(sums[qty]) >>> 1;
         counts[qty] = counts[qty] >> 1;
      end
   endfunction

   // Truncating, saturating average of one quantity; clears it afterwards
   function automatic average_reading_type close_average(input logic [QTY_W-1:0] qty);
      average_reading_type r;
      logic                neg;
      logic [SUM_W-1:0]    mag;
      logic [SUM_W-1:0]    quot;
      r = '0;
      r.quantity = qty;
      if (counts[qty] != 0) begin
         neg = sums[qty][SUM_W-1];
         mag = neg ? -sums[qty] : sums[qty];
         quot = mag / {{(SUM_W - CNT_W){1'b0}}, counts[qty]};
         if (neg)
            r.average = (quot > SUM_W'(AVG_MIN)) ? AVG_MIN : SAMPLE_W'(-quot);
         else
            r.average = (quot > SUM_W'(AVG_MAX)) ? AVG_MAX : SAMPLE_W'(quot);
         r.has_data = 1'b1;
      end
      sums[qty] = '0;
      counts[qty] = '0;
      return r;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t checker: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      average_reading_type got;
      average_reading_type want;
      logic [QTY_W-1:0]    qty;
      logic                is_read;
      if (reset) begin
         for (int i = 0; i < NUM_QTY; i++) begin
            sums[i] = '0;
            counts[i] = '0;
         end
         elapsed_ms = '0;
         ext_enabled = 1'b0;
         stale_limit = TIMEOUT_RESET;
         pending_readings.delete();
      end else begin
         // Compare a result beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_quantity, rsp_has_data, rsp_average, rsp_fresh, rsp_source_present};
            if (pending_readings.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t checker: result beat expected none actual %0h", $time, got);
            end else begin
               want = pending_readings.pop_front();
               check_field("quantity", want.quantity, got.quantity);
               check_field("has_data", want.has_data, got.has_data);
               check_field("average", want.average, got.average);
               check_field("fresh", want.fresh, got.fresh);
               check_field("source_present", want.source_present, got.source_present);
            end
         end

         // Track register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_EXT_ENABLED: ext_enabled = csr_wdata[0];
               CSR_TIMEOUT:     stale_limit = TIMEOUT_W'(csr_wdata);
               default: ;
            endcase
         end

         // Advance the shadow state on every request beat
         if (req_valid && req_ready) begin
            is_read = 1'b0;
            qty = QTY_PRESSURE;
            case (req_kind)
               KIND_SAMPLE: begin
                  add_to_sum(QTY_PRESSURE, req_pressure_sample);
                  add_to_sum(QTY_TEMPERATURE, req_temperature_sample);
                  add_to_sum(QTY_AIRSPEED, req_airspeed_sample);
                  elapsed_ms = '0;
               end
               KIND_TICK: begin
                  if (elapsed_ms != ELAPSED_MAX)
                     elapsed_ms = elapsed_ms + 1'b1;
               end
               KIND_READ_PRESSURE: begin
                  is_read = 1'b1;
                  qty = QTY_PRESSURE;
               end
               KIND_READ_TEMPERATURE: begin
                  is_read = 1'b1;
                  qty = QTY_TEMPERATURE;
               end
               KIND_READ_AIRSPEED: begin
                  is_read = 1'b1;
                  qty = QTY_AIRSPEED;
               end
               // drop unused kinds
               default: ;
            endcase
            if (is_read) begin
               want = close_average(qty);
               want.fresh = (qty == QTY_AIRSPEED) && want.has_data && (elapsed_ms < stale_limit);
               want.source_present = ext_enabled;
               pending_readings.push_back(want);
            end
         end
      end
      outstanding <= pending_readings.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ssa_pkg::*;

   localparam int MAX_COUNT     = 100;
   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 750;
   localparam int PHASES        = 6;
   localparam int TICK_RUN      = 40;
   localparam logic [KIND_W-1:0] KIND_LAST = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind = KIND_SAMPLE;
   logic [SAMPLE_W-1:0]   req_pressure_sample = '0;
   logic [SAMPLE_W-1:0]   req_temperature_sample = '0;
   logic [SAMPLE_W-1:0]   req_airspeed_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [QTY_W-1:0]      rsp_quantity;
   logic                  rsp_has_data;
   logic [SAMPLE_W-1:0]   rsp_average;
   logic                  rsp_fresh;
   logic                  rsp_source_present;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_EXT_ENABLED;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                    mismatch_count;
   int                    outstanding;
   int                    idle_cycles = 0;
   int                    burst_left = 0;
   int                    items_sent = 0;
   int                    ready_run = 0;
   logic                  ready_level = 1'b1;
   logic [TIMEOUT_W-1:0]  cur_timeout = TIMEOUT_RESET;

   initial begin
      forever #1 clock = ~clock;
   end

   sensor_sample_averager #(.MAX_COUNT(MAX_COUNT)) u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_kind               (req_kind),
      .req_pressure_sample    (req_pressure_sample),
      .req_temperature_sample (req_temperature_sample),
      .req_airspeed_sample    (req_airspeed_sample),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_quantity           (rsp_quantity),
      .rsp_has_data           (rsp_has_data),
      .rsp_average            (rsp_average),
      .rsp_fresh              (rsp_fresh),
      .rsp_source_present     (rsp_source_present),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   averager_checker #(.MAX_COUNT(MAX_COUNT)) u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_kind               (req_kind),
      .req_pressure_sample    (req_pressure_sample),
      .req_temperature_sample (req_temperature_sample),
      .req_airspeed_sample    (req_airspeed_sample),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_quantity           (rsp_quantity),
      .rsp_has_data           (rsp_has_data),
      .rsp_average            (rsp_average),
      .rsp_fresh              (rsp_fresh),
      .rsp_source_present     (rsp_source_present),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .mismatch_count         (mismatch_count),
      .outstanding            (outstanding)
   );

   // Receiver: runs of ready and stall of random length, with long open stretches
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_level = ($urandom_range(0, 2) != 0);
         if (ready_level)
            ready_run = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
         else
            ready_run = $urandom_range(1, 30);
      end
      ready_run--;
      rsp_ready <= ready_level;
   end

   // Count cycles without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return AVG_MAX;
         1: return AVG_MIN;
         2: return '0;
         3: return '1;
         4: return SAMPLE_W'($urandom_range(0, 1023)) - SAMPLE_W'(512);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] random_read_kind();
      case ($urandom_range(0, 2))
         0: return KIND_READ_PRESSURE;
         1: return KIND_READ_TEMPERATURE;
         default: return KIND_READ_AIRSPEED;
      endcase
   endfunction

   // Present one beat and hold it until taken; paced beats come in bursts with gaps
   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic [SAMPLE_W-1:0] p,
                            input logic [SAMPLE_W-1:0] t,
                            input logic [SAMPLE_W-1:0] a,
                            input bit paced = 1'b1);
      int gap;
      if (paced && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pressure_sample <= p;
      req_temperature_sample <= t;
      req_airspeed_sample <= a;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0)
         burst_left--;
      items_sent++;
   endtask

   task automatic send_read(input logic [KIND_W-1:0] kind);
      send_item(kind, random_sample(), random_sample(), random_sample());
   endtask

   // Hold off until every predicted result is back and the block has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic ext, input logic [TIMEOUT_W-1:0] tmo);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_EXT_ENABLED;
      csr_wdata <= {junk[CSR_DATA_W-1:1], ext};
      @(posedge clock);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= CSR_DATA_W'(tmo);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_timeout = tmo;
   endtask

   // Samples, then ticks (up to just past the timeout when it is short), then reads in random order
   task automatic run_window(input int n_samples);
      bit                  steady;
      logic [SAMPLE_W-1:0] a_fixed;
      int                  ticks;
      steady = (n_samples > MAX_COUNT) && ($urandom_range(0, 1) == 1);
      a_fixed = random_sample();
      for (int i = 0; i < n_samples; i++) begin
         if (steady)
            send_item(KIND_SAMPLE, AVG_MAX, AVG_MIN, a_fixed);
         else
            send_item(KIND_SAMPLE, random_sample(), random_sample(), random_sample());
      end
      ticks = (cur_timeout <= 40) ? $urandom_range(0, cur_timeout + 2) : $urandom_range(0, 4);
      repeat (ticks) send_item(KIND_TICK, random_sample(), random_sample(), random_sample());
      repeat ($urandom_range(2, 4)) send_read(random_read_kind());
   endtask

   initial begin : stimulus
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty reads, then unused kinds
      send_read(KIND_READ_PRESSURE);
      send_read(KIND_READ_TEMPERATURE);
      send_read(KIND_READ_AIRSPEED);
      for (int k = KIND_TICK + 1; k <= KIND_LAST; k++)
         send_item(KIND_W'(k), random_sample(), random_sample(), random_sample());

      // Field extremes through a single-sample average
      send_item(KIND_SAMPLE, AVG_MAX, AVG_MIN, '0);
      send_read(KIND_READ_AIRSPEED);
      send_read(KIND_READ_PRESSURE);
      send_read(KIND_READ_TEMPERATURE);

      // Truncation toward zero on negative sums, fresh airspeed after two ticks
      send_item(KIND_SAMPLE, -SAMPLE_W'(3), SAMPLE_W'(3), SAMPLE_W'(5));
      send_item(KIND_SAMPLE, '0, '0, '0);
      send_item(KIND_TICK, random_sample(), random_sample(), random_sample());
      send_item(KIND_TICK, random_sample(), random_sample(), random_sample());
      send_read(KIND_READ_PRESSURE);
      send_read(KIND_READ_TEMPERATURE);
      send_read(KIND_READ_AIRSPEED);

      // Most negative sum divided exactly
      send_item(KIND_SAMPLE, AVG_MIN, AVG_MIN, AVG_MIN);
      send_item(KIND_SAMPLE, AVG_MIN, AVG_MIN, AVG_MIN);
      send_read(KIND_READ_PRESSURE);
      send_read(KIND_READ_TEMPERATURE);
      send_read(KIND_READ_AIRSPEED);

      // Halving past the count limit saturates the average; ticks back to back
      wait_idle();
      configure(1'b1, '1);
      repeat (MAX_COUNT + 1) send_item(KIND_SAMPLE, AVG_MAX, AVG_MIN, AVG_MAX, 1'b0);
      repeat (TICK_RUN)
         send_item(KIND_TICK, random_sample(), random_sample(), random_sample(), 1'b0);
      send_read(KIND_READ_PRESSURE);
      send_read(KIND_READ_TEMPERATURE);
      send_read(KIND_READ_AIRSPEED);

      // Random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: configure(1'b0, '0);
            1: configure(1'b1, TIMEOUT_W'(1));
            2: configure(1'b0, TIMEOUT_RESET);
            3: configure(1'b1, '1);
            default: configure(1'($urandom_range(0, 1)),
                               ($urandom_range(0, 1) == 1) ? TIMEOUT_W'($urandom_range(1, 30))
                                                           : TIMEOUT_W'($urandom));
         endcase
         target = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < target) begin
            case ($urandom_range(0, 24))
               0, 1, 2:
                  repeat ($urandom_range(1, 6))
                     send_item(KIND_W'($urandom_range(0, KIND_LAST)),
                               random_sample(), random_sample(), random_sample());
               3: run_window($urandom_range(MAX_COUNT - 10, MAX_COUNT + 30));
               default: run_window($urandom_range(1, 12));
            endcase
         end
      end

      wait_idle();
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ssa_pkg.sv
rtl/ssa_div.sv
rtl/ssa_dp.sv
rtl/ssa_ctrl.sv
rtl/sensor_sample_averager.sv
bench/averager_checker.sv
bench/testbench.sv
